FILE: rtl/upd_pkg.sv
// shared types, constants and hex helper for the url percent decoder
package upd_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [4:0] HEX_LETTER_BASE = 5'd10;
   localparam logic [4:0] HEX_NONE = 5'd16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // results of one item, count is 1 to 3
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] count;
      logic       last;
   } upd_job_type;

   // digit value in the low four bits, bit 4 set when not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      v = HEX_NONE;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = 5'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = 5'(b - 8'h61) + HEX_LETTER_BASE;
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = 5'(b - 8'h41) + HEX_LETTER_BASE;
      end
      return v;
   endfunction

endpackage

FILE: rtl/upd_front.sv
// front end: accepts input bytes, tracks pending escape and builds result jobs
module upd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_byte,
   input  logic                req_last,
   input  logic                q_full,
   output logic                push,
   output upd_pkg::upd_job_type push_job
);
   import upd_pkg::*;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_PCT  = 2'd1;
   localparam logic [1:0] PEND_HEX  = 2'd2;

   logic [1:0] pend_ff, pend_in;
   logic [7:0] pbyte_ff, pbyte_in;
   logic       accept;
   logic [4:0] hb, hp;
   logic       b_hex;
   logic       fpend;
   logic [7:0] fbyte;
   upd_job_type job;

   assign req_ready = !q_full;
   assign accept = req_valid && req_ready;

   always_comb begin
      hb = hex_value(req_byte);
      hp = hex_value(pbyte_ff);
      b_hex = !hb[4];
      fpend = (req_byte == CH_PERCENT) && !req_last;
      fbyte = (req_byte == CH_PLUS) ? CH_SPACE : req_byte;
      job.byte0 = CH_PERCENT;
      job.byte1 = pbyte_ff;
      job.byte2 = fbyte;
      job.count = 2'd0;
      job.last = req_last;
      pend_in = PEND_NONE;
      pbyte_in = pbyte_ff;
      unique case (pend_ff)
         PEND_PCT: begin
            if (b_hex) begin
               if (req_last) begin
                  job.byte1 = req_byte;
                  job.count = 2'd2;
               end else begin
                  pend_in = PEND_HEX;
                  pbyte_in = req_byte;
               end
            end else begin
               job.byte1 = fbyte;
               job.count = fpend ? 2'd1 : 2'd2;
               pend_in = fpend ? PEND_PCT : PEND_NONE;
            end
         end
         PEND_HEX: begin
            if (b_hex) begin
               job.byte0 = {hp[3:0], hb[3:0]};
               job.count = 2'd1;
            end else begin
               job.count = fpend ? 2'd2 : 2'd3;
               pend_in = fpend ? PEND_PCT : PEND_NONE;
            end
         end
         default: begin
            job.byte0 = fbyte;
            job.count = fpend ? 2'd0 : 2'd1;
            pend_in = fpend ? PEND_PCT : PEND_NONE;
         end
      endcase
   end

   assign push = accept && (job.count != 2'd0);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_NONE;
         pbyte_ff <= 8'd0;
      end else if (accept) begin
         pend_ff <= pend_in;
         pbyte_ff <= pbyte_in;
      end
   end

endmodule

FILE: rtl/upd_queue.sv
// short job queue between front and back ends
module upd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  upd_pkg::upd_job_type push_job,
   input  logic                 pop,
   output upd_pkg::upd_job_type pop_job,
   output logic                 q_valid,
   output logic                 q_full
);
   import upd_pkg::*;

   upd_job_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, rptr_ff;
   logic [QCNT_W-1:0] cnt_ff;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign q_valid = (cnt_ff != '0);
   assign q_full = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_job = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wptr_ff <= next_ptr(wptr_ff);
         if (pop) rptr_ff <= next_ptr(rptr_ff);
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("queue pop while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_job_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_job.count != 2'd0))
      else $error("empty job pushed");

endmodule

FILE: rtl/upd_back.sv
// back end: holds one job and emits its result bytes one per cycle while rsp_ready is high
module upd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  upd_pkg::upd_job_type pop_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_byte,
   output logic                 rsp_run_end,
   output logic                 rsp_string_end
);
   import upd_pkg::*;

   upd_job_type job_ff;
   logic [1:0]  idx_ff;
   logic        valid_ff;
   logic        run_end;
   logic        done;

   assign run_end = (idx_ff == job_ff.count - 2'd1);
   assign done = valid_ff && rsp_ready && run_end;
   assign pop = q_valid && (!valid_ff || done);

   always_comb begin
      case (idx_ff)
         2'd0: rsp_byte = job_ff.byte0;
         2'd1: rsp_byte = job_ff.byte1;
         default: rsp_byte = job_ff.byte2;
      endcase
   end

   assign rsp_valid = valid_ff;
   assign rsp_run_end = run_end;
   assign rsp_string_end = run_end && job_ff.last;

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= pop_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else if (pop) begin
         valid_ff <= 1'b1;
         idx_ff <= 2'd0;
      end else if (done) begin
         valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else if (valid_ff && rsp_ready) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

endmodule

FILE: rtl/url_percent_decoder.sv
// top level of the url percent decoder
//
// input channel req_*: one raw byte per item, req_last on the final byte of
// a string. result channel rsp_*: one decoded byte per item, rsp_run_end on
// the last result caused by an input item, rsp_string_end on the final
// decoded byte of the string. both channels use valid/ready.
// the front end decodes '%' escapes and '+' and holds a pending '%' and one
// pending hex digit; it builds a job of one to three result bytes per input
// (none while an escape is still pending). a two-entry job queue sits
// between it and the back end, which emits the job's bytes one per cycle
// while the receiver is ready. the first result of an item is registered
// in the queue and then in the back end's job register. throughput: one
// input per cycle while each gives at most one result and the receiver
// is ready; a string end or a broken escape gives up to three results,
// which leave one at a time through the single output port of the back end.
// reset clears pending state, the queue and the output. when the receiver
// stalls, results hold, the queue fills and req_ready drops when it is full.
module url_percent_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte,
   output logic       rsp_run_end,
   output logic       rsp_string_end
);
   import upd_pkg::*;

   logic        push;
   logic        pop;
   logic        q_valid;
   logic        q_full;
   upd_job_type push_job;
   upd_job_type pop_job;

   upd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .q_full    (q_full),
      .push      (push),
      .push_job  (push_job)
   );

   upd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_valid  (q_valid),
      .q_full   (q_full)
   );

   upd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .pop_job        (pop_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte       (rsp_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the url percent decoder, with an item-level decode model
`timescale 1ns / 1ps

module testbench;
   import upd_pkg::*;

   localparam int ITEM_TARGET = 350;
   localparam int CALM_ITEMS = 60;
   localparam int DRAIN_CYCLES = 10;
   localparam int STALL_LIMIT = 2000;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_PERCENT,
      PEND_DIGIT
   } pend_state_type;

   typedef struct {
      logic [7:0] data;
      logic       run_end;
      logic       string_end;
   } decoded_type;

   typedef logic [7:0] byte_q_type[$];

   class decode_scoreboard;
      decoded_type    expected_q[$];
      logic [7:0]     step_q[$];
      pend_state_type state;
      logic [7:0]     held_digit;
      int             errors;

      function new();
         state = PEND_NONE;
         held_digit = 8'h00;
         errors = 0;
      endfunction

      function int hex_digit(logic [7:0] b);
         if (b >= "0" && b <= "9") return b - "0";
         if (b >= "a" && b <= "f") return b - "a" + 10;
         if (b >= "A" && b <= "F") return b - "A" + 10;
         return 16;
      endfunction

      function void add_step(logic [7:0] b);
         step_q.insert(step_q.size(), b);
      endfunction

      function void take_fresh(logic [7:0] b, logic last);
         if (b == CH_PERCENT) begin
            if (last) add_step(CH_PERCENT);
            else state = PEND_PERCENT;
         end else if (b == CH_PLUS) begin
            add_step(CH_SPACE);
         end else begin
            add_step(b);
         end
      endfunction

      function void note_item(logic [7:0] b, logic last);
         pend_state_type was;
         decoded_type    r;
         int             lo;
         int             hi;
         was = state;
         state = PEND_NONE;
         step_q.delete();
         case (was)
            PEND_PERCENT: begin
               if (hex_digit(b) < 16) begin
                  if (last) begin
                     add_step(CH_PERCENT);
                     add_step(b);
                  end else begin
                     state = PEND_DIGIT;
                     held_digit = b;
                  end
               end else begin
                  add_step(CH_PERCENT);
                  take_fresh(b, last);
               end
            end
            PEND_DIGIT: begin
               lo = hex_digit(b);
               hi = hex_digit(held_digit);
               if (lo < 16 && hi < 16) begin
                  add_step(8'(hi * 16 + lo));
               end else begin
                  add_step(CH_PERCENT);
                  add_step(held_digit);
                  take_fresh(b, last);
               end
            end
            default: begin
               take_fresh(b, last);
            end
         endcase
         if (last) state = PEND_NONE;
         foreach (step_q[i]) begin
            r.data = step_q[i];
            r.run_end = (i == step_q.size() - 1);
            r.string_end = last && (i == step_q.size() - 1);
            expected_q.insert(expected_q.size(), r);
         end
      endfunction

      function void check_result(logic [7:0] b, logic run_end, logic string_end);
         decoded_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result: byte %h run_end %b string_end %b",
                   b, run_end, string_end);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (b !== e.data) begin
            $error("rsp_byte: expected %h, got %h", e.data, b);
            errors++;
         end
         if (run_end !== e.run_end) begin
            $error("rsp_run_end: expected %b, got %b", e.run_end, run_end);
            errors++;
         end
         if (string_end !== e.string_end) begin
            $error("rsp_string_end: expected %b, got %b", e.string_end, string_end);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_byte = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_byte;
   logic       rsp_run_end;
   logic       rsp_string_end;

   decode_scoreboard sb = new();
   int  item_count = 0;
   bit  idling = 1'b1;
   int  stall_left = 0;
   int  quiet_cycles = 0;

   url_percent_decoder uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte       (req_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte       (rsp_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

   always #6 clock = ~clock;

   // receiver with random stall bursts, and result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_byte, rsp_run_end, rsp_string_end);
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[url_percent_decoder] ERROR");
         $finish;
      end
   end

   task automatic send_item(input logic [7:0] b, input logic last);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte <= b;
      req_last <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_item(b, last);
      item_count++;
   endtask

   task automatic send_string(input byte_q_type q);
      foreach (q[i]) send_item(q[i], i == q.size() - 1);
   endtask

   function automatic byte_q_type text_bytes(string s);
      byte_q_type q;
      for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
      return q;
   endfunction

   function automatic logic [7:0] rand_hex();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      if ($urandom_range(0, 1) == 1) return 8'("a" + v - 10);
      return 8'("A" + v - 10);
   endfunction

   function automatic byte_q_type rand_string();
      byte_q_type q;
      int         len;
      int         pick;
      len = $urandom_range(1, 10);
      while (q.size() < len) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            q.insert(q.size(), CH_PERCENT);
            q.insert(q.size(), rand_hex());
            q.insert(q.size(), rand_hex());
         end else if (pick < 55) begin
            q.insert(q.size(), CH_PLUS);
         end else if (pick < 62) begin
            q.insert(q.size(), CH_PERCENT);
            q.insert(q.size(), rand_hex());
            q.insert(q.size(), 8'($urandom_range(0, 255)));
         end else if (pick < 68) begin
            q.insert(q.size(), CH_PERCENT);
            q.insert(q.size(), 8'($urandom_range(0, 255)));
         end else if (pick < 72) begin
            q.insert(q.size(), CH_PERCENT);
         end else begin
            q.insert(q.size(), 8'($urandom_range(0, 255)));
         end
      end
      return q;
   endfunction

   initial begin
      string directed[$];
      directed = '{"+", "%", "%4", "%4a", "%%41", "%+", "%4G", "%fF", "%%"};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      foreach (directed[i]) send_string(text_bytes(directed[i]));

      while (item_count < ITEM_TARGET) begin
         if (item_count >= ITEM_TARGET - CALM_ITEMS) idling = 1'b0;
         send_string(rand_string());
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[url_percent_decoder] OK");
      end else begin
         $display("[url_percent_decoder] ERROR");
      end
      $finish;
   end

endmodule

FILE: url_percent_decoder.f
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
tb/sv/testbench.sv
